// File: design/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// No dependencies; used by bdq_ram, bdq_ctrl and bounded_double_ended_queue.
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = 11;
  localparam int CMD_W         = 2;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [CNT_W-1:0]         CAP_RESET  = 11'd1024;
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_REAR  = 2'd1,
    CMD_DEL_FRONT = 2'd2,
    CMD_DEL_REAR  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

// File: design/bdq_ram.sv
// Entry store: single write port, single read port, registered read data.
// Uses bdq_pkg for the word width.
module bdq_ram #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [bdq_pkg::DATA_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [bdq_pkg::DATA_W-1:0] rd_data
);

  logic signed [bdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [bdq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/bdq_ctrl.sv
// Queue control: head/tail pointers, count, capacity register, cached end words
// and the result register. Depends on bdq_pkg; drives the bdq_ram ports.
module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bdq_pkg::CNT_W-1:0]         cfg_capacity,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic signed [bdq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [bdq_pkg::DATA_W-1:0] out_rear_value,
  output logic                              out_empty_flag,
  output logic                              out_full_flag,
  output logic [bdq_pkg::CNT_W-1:0]         out_entry_count,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic signed [bdq_pkg::DATA_W-1:0] ram_wdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr,
  input  logic signed [bdq_pkg::DATA_W-1:0] ram_rdata
);

  localparam int CW      = bdq_pkg::CNT_W;
  localparam int CAP_TOP = (1 << CW) - 1;
  localparam int CAP_MAX = (DEPTH > CAP_TOP) ? CAP_TOP : DEPTH;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  bdq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cap_r, cap_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            ok_r, ok_nxt;
  logic            full_r, full_nxt;
  logic            pend_front_r, pend_front_nxt;
  logic signed [bdq_pkg::DATA_W-1:0] front_r, front_nxt;
  logic signed [bdq_pkg::DATA_W-1:0] rear_r, rear_nxt;

  logic            acc;
  logic            full_now;
  logic            empty_now;
  logic [CW-1:0]   cap_eff;
  logic [AW-1:0]   head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
  bdq_pkg::cmd_t   cmd;

  always_comb begin
    head_inc  = (head_r == LAST) ? '0 : head_r + 1'b1;
    head_dec  = (head_r == '0) ? LAST : head_r - 1'b1;
    tail_inc  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    tail_dec  = (tail_r == '0) ? LAST : tail_r - 1'b1;
    tail_dec2 = (tail_dec == '0) ? LAST : tail_dec - 1'b1;
  end

  assign cap_eff   = (cap_r > CW'(CAP_MAX)) ? CW'(CAP_MAX) : cap_r;
  assign full_now  = (count_r >= cap_eff);
  assign empty_now = (count_r == '0);
  assign in_stall  = (state_r != bdq_pkg::ST_RUN) || (out_valid_r && out_stall);
  assign acc       = in_valid && !in_stall;
  assign cmd       = bdq_pkg::cmd_t'(in_cmd);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    cap_nxt        = cfg_wr_en ? cfg_capacity : cap_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ok_nxt         = ok_r;
    full_nxt       = full_r;
    pend_front_nxt = pend_front_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    ram_we         = 1'b0;
    ram_waddr      = head_dec;
    ram_wdata      = in_value;
    ram_re         = 1'b0;
    ram_raddr      = head_inc;

    unique case (state_r)
      bdq_pkg::ST_RUN: begin
        if (acc) begin
          ok_nxt        = 1'b0;
          out_valid_nxt = 1'b1;
          unique case (cmd)
            bdq_pkg::CMD_INS_FRONT: begin
              if (!full_now) begin
                head_nxt  = head_dec;
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                count_nxt = count_r + 1'b1;
                front_nxt = in_value;
                if (empty_now) begin
                  rear_nxt = in_value;
                end
                ok_nxt = 1'b1;
              end
            end
            bdq_pkg::CMD_INS_REAR: begin
              if (!full_now) begin
                tail_nxt  = tail_inc;
                ram_we    = 1'b1;
                ram_waddr = tail_r;
                count_nxt = count_r + 1'b1;
                rear_nxt  = in_value;
                if (empty_now) begin
                  front_nxt = in_value;
                end
                ok_nxt = 1'b1;
              end
            end
            bdq_pkg::CMD_DEL_FRONT: begin
              if (!empty_now) begin
                head_nxt       = head_inc;
                count_nxt      = count_r - 1'b1;
                ram_re         = 1'b1;
                ram_raddr      = head_inc;
                pend_front_nxt = 1'b1;
                state_nxt      = bdq_pkg::ST_READ;
                out_valid_nxt  = 1'b0;
                ok_nxt         = 1'b1;
              end
            end
            bdq_pkg::CMD_DEL_REAR: begin
              if (!empty_now) begin
                tail_nxt       = tail_dec;
                count_nxt      = count_r - 1'b1;
                ram_re         = 1'b1;
                ram_raddr      = tail_dec2;
                pend_front_nxt = 1'b0;
                state_nxt      = bdq_pkg::ST_READ;
                out_valid_nxt  = 1'b0;
                ok_nxt         = 1'b1;
              end
            end
            default: ;
          endcase
          full_nxt = (count_nxt >= cap_eff);
        end
      end
      bdq_pkg::ST_READ: begin
        // new end word arrives from the store; publish the result now
        if (pend_front_r) begin
          front_nxt = ram_rdata;
        end else begin
          rear_nxt = ram_rdata;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = bdq_pkg::ST_RUN;
      end
      default: state_nxt = bdq_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_RUN;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cap_r       <= bdq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r         <= ok_nxt;
    full_r       <= full_nxt;
    pend_front_r <= pend_front_nxt;
    front_r      <= front_nxt;
    rear_r       <= rear_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_empty_flag  = (count_r == '0);
  assign out_full_flag   = full_r;
  assign out_entry_count = count_r;
  assign out_front_value = (count_r == '0) ? bdq_pkg::EMPTY_WORD : front_r;
  assign out_rear_value  = (count_r == '0) ? bdq_pkg::EMPTY_WORD : rear_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP_MAX))
    else $error("entry count beyond store depth");

  a_read_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdq_pkg::ST_READ |-> !out_valid_r)
    else $error("result shown while end word fetch pending");

  a_del_goes_read: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ram_re) |=> (state_r == bdq_pkg::ST_READ))
    else $error("delete did not fetch new end word");

  a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !ok_nxt) |=> ($stable(count_r) && $stable(head_r) && $stable(tail_r)))
    else $error("refused operation changed queue state");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");
`endif

endmodule

// File: design/bounded_double_ended_queue.sv
// Result timing: an insert or refused op has its result beat registered in the cycle after accept;
//   a carried-out delete passes through the read state (one store read) before its result beat.
// Throughput: inserts and refused ops 1 beat/cycle while the receiver does not stall;
//   after a delete no new beat is taken until the store read of the new end word lands.
// Reset (rst_n low, synchronous): queue empty, pointers zero, capacity 1024,
//   no result pending. The entry store is not cleared; no clearing pass is needed.
module bounded_double_ended_queue #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: capacity register, write-only
  input  logic                              cfg_wr_en,
  input  logic [bdq_pkg::CNT_W-1:0]         cfg_capacity,
  // operation beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic signed [bdq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [bdq_pkg::DATA_W-1:0] out_rear_value,
  output logic                              out_empty_flag,
  output logic                              out_full_flag,
  output logic [bdq_pkg::CNT_W-1:0]         out_entry_count
);

  localparam int AW = $clog2(DEPTH);

  // Store access from the controller. Inserts write the new slot at accept;
  // deletes read the slot that becomes the new front or rear. Only one access
  // happens per operation and the controller holds off the next beat until the
  // read data has landed, so no forwarding path is required.
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic signed [bdq_pkg::DATA_W-1:0] ram_wdata;
  logic                              ram_re;
  logic [AW-1:0]                     ram_raddr;
  logic signed [bdq_pkg::DATA_W-1:0] ram_rdata;

  // Controller: ring pointers, count, capacity, cached end words and the
  // result register. The front/rear words live in flops so that an insert
  // reports without touching the store.
  bdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_capacity    (cfg_capacity),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_empty_flag  (out_empty_flag),
    .out_full_flag   (out_full_flag),
    .out_entry_count (out_entry_count),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  // Entry store: DEPTH words, one write and one registered read per cycle.
  bdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for bounded_double_ended_queue: directed table, then random phases.
// Depends on bdq_pkg (command codes, widths, capacity reset value, empty word) and the DUT.
// Each accepted op beat is run through a local deque predictor; result beats are checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int SLOTS       = DEPTH_DEFAULT;
  localparam int SETTLE      = 4;       // outlasts the result path of a delete
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off, fills the block
  localparam int CYCLE_LIMIT = 100000;  // watchdog limit, well above a correct run

  // Per-phase choice of which ops the random part draws.
  typedef enum {
    MIX_UNIFORM,   // all four ops equally likely
    MIX_INSERTS    // front/rear inserts only, used to fill the queue
  } op_mix_t;

  // One result beat, field by field.
  typedef struct {
    logic                     ok;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] rear;
    logic                     empty;
    logic                     full;
    logic [CNT_W-1:0]         count;
  } deque_result_t;

  // One row of the directed table: either a capacity write or an op beat.
  // Rows with typed set carry a hand-written expected result.
  typedef struct {
    bit                       is_cfg;
    logic [CNT_W-1:0]         cap;
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    deque_result_t            want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     cfg_wr_en    = 1'b0;
  logic [CNT_W-1:0]         cfg_capacity = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd       = '0;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;
  logic                     out_empty_flag;
  logic                     out_full_flag;
  logic [CNT_W-1:0]         out_entry_count;

  bounded_double_ended_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_capacity    (cfg_capacity),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_empty_flag  (out_empty_flag),
    .out_full_flag   (out_full_flag),
    .out_entry_count (out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deque predictor state: ring of words, front slot, slot past the rear,
  // entry count and the capacity register as last written.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] ring_words [SLOTS];
  logic [$clog2(SLOTS)-1:0] front_slot  = '0;
  logic [$clog2(SLOTS)-1:0] past_rear   = '0;
  logic [CNT_W-1:0]         held        = '0;
  logic [CNT_W-1:0]         cap_reg     = CAP_RESET;

  deque_result_t expected_results [$];  // oldest first
  dir_row_t      directed_rows [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  pressure_on   = 1'b0;
  int  held_cycles   = 0;
  int  mismatches    = 0;
  int  cycle_count   = 0;

  // Apply one op to the predicted deque and return the result it reports.
  // Slot indexes are exactly log2(SLOTS) bits wide, so +/-1 wraps the ring.
  function automatic deque_result_t deque_apply(cmd_t op, logic signed [DATA_W-1:0] word);
    deque_result_t            r;
    logic [CNT_W-1:0]         limit;
    logic [$clog2(SLOTS)-1:0] rear_slot;
    logic                     was_full;
    logic                     was_empty;
    // capacity above the ring depth saturates at the depth
    limit     = (cap_reg > SLOTS) ? CNT_W'(SLOTS) : cap_reg;
    was_full  = held >= limit;   // capacity 0: empty and full at once
    was_empty = held == '0;
    r.ok      = 1'b0;
    case (op)
      CMD_INS_FRONT: begin
        if (!was_full) begin
          front_slot = front_slot - 1'b1;
          ring_words[front_slot] = word;
          held = held + 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_INS_REAR: begin
        if (!was_full) begin
          ring_words[past_rear] = word;
          past_rear = past_rear + 1'b1;
          held = held + 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_FRONT: begin
        if (!was_empty) begin
          front_slot = front_slot + 1'b1;
          held = held - 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (!was_empty) begin
          past_rear = past_rear - 1'b1;
          held = held - 1'b1;
          r.ok = 1'b1;
        end
      end
    endcase
    rear_slot = past_rear - 1'b1;
    r.empty   = held == '0;
    r.front   = r.empty ? EMPTY_WORD : ring_words[front_slot];
    r.rear    = r.empty ? EMPTY_WORD : ring_words[rear_slot];
    r.full    = held >= limit;   // stays set while count sits above a lowered capacity
    r.count   = held;
    return r;
  endfunction

  // Random payload, leaning on the extremes now and then.
  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return EMPTY_WORD;   // a stored -1 must not read as empty
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // --- directed table builders ---
  function automatic void add_op(cmd_t op, logic signed [DATA_W-1:0] word);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cap    = '0;
    row.cmd    = op;
    row.value  = word;
    row.typed  = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(cmd_t op, logic signed [DATA_W-1:0] word, logic ok,
                                      logic signed [DATA_W-1:0] front,
                                      logic signed [DATA_W-1:0] rear,
                                      logic empty, logic full, logic [CNT_W-1:0] count);
    dir_row_t row;
    row.is_cfg     = 1'b0;
    row.cap        = '0;
    row.cmd        = op;
    row.value      = word;
    row.typed      = 1'b1;
    row.want.ok    = ok;
    row.want.front = front;
    row.want.rear  = rear;
    row.want.empty = empty;
    row.want.full  = full;
    row.want.count = count;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cap(logic [CNT_W-1:0] cap);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.cap    = cap;
    row.cmd    = CMD_INS_FRONT;
    row.value  = '0;
    row.typed  = 1'b0;
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Capacity write. Only while idle: every expected beat back, then a short
  // settle so nothing is still in flight inside the block.
  // Called in the time step of the last accept, so in_valid drops at once.
  // ---------------------------------------------------------------------------
  task automatic write_capacity(logic [CNT_W-1:0] cap);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    cap_reg   = cap;
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one op beat, with random idle cycles ahead of it, and hold it
  // until accepted. Sampling right after the edge sees pre-edge values.
  task automatic send_op(cmd_t op, logic signed [DATA_W-1:0] word, bit typed,
                         deque_result_t want);
    deque_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= op;
    in_value <= word;
    do @(posedge clk); while (in_stall);
    // predictor runs on every beat so its state tracks the typed rows too
    predicted = deque_apply(op, word);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_random(int beats, op_mix_t mix);
    cmd_t          op;
    deque_result_t unused = '{default: '0};
    for (int i = 0; i < beats; i++) begin
      if (mix == MIX_INSERTS)
        op = $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
      else
        op = cmd_t'($urandom_range(0, 3));
      send_op(op, random_word(), 1'b0, unused);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check accepted beats in order, then pick the next stall.
  // During the pressure window the stall is held high for HOLD_CYCLES.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no op outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok",          DATA_W'(want.ok),    DATA_W'(out_ok));
        check_field("front_value", want.front,          out_front_value);
        check_field("rear_value",  want.rear,           out_rear_value);
        check_field("empty_flag",  DATA_W'(want.empty), DATA_W'(out_empty_flag));
        check_field("full_flag",   DATA_W'(want.full),  DATA_W'(out_full_flag));
        check_field("entry_count", DATA_W'(want.count), DATA_W'(out_entry_count));
      end
    end
    if (pressure_on && held_cycles < HOLD_CYCLES) begin
      out_stall   <= 1'b1;
      held_cycles <= held_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    // Capacity 1024 after reset: deletes on an empty queue, extremes of the
    // word, a stored -1 at the rear, then drain back to empty.
    add_checked(CMD_DEL_FRONT, 32'sd0, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0);
    add_checked(CMD_DEL_REAR,  32'sd0, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0);
    add_checked(CMD_INS_FRONT, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                1'b0, 1'b0, 11'd1);
    add_checked(CMD_INS_REAR,  32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                1'b0, 1'b0, 11'd2);
    add_checked(CMD_INS_FRONT, 32'sd0, 1'b1, 32'sd0, 32'sh8000_0000, 1'b0, 1'b0, 11'd3);
    add_checked(CMD_INS_REAR,  EMPTY_WORD, 1'b1, 32'sd0, EMPTY_WORD, 1'b0, 1'b0, 11'd4);
    add_checked(CMD_DEL_FRONT, 32'sd0, 1'b1, 32'sh7FFF_FFFF, EMPTY_WORD, 1'b0, 1'b0, 11'd3);
    add_checked(CMD_DEL_REAR,  32'sd0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                1'b0, 1'b0, 11'd2);
    add_checked(CMD_DEL_REAR,  32'sd0, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                1'b0, 1'b0, 11'd1);
    add_checked(CMD_DEL_FRONT, 32'sd0, 1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0);
    // capacity 1: one insert fills it, the next is refused
    add_cap(11'd1);
    add_checked(CMD_INS_REAR,  32'sh1234_5678, 1'b1, 32'sh1234_5678, 32'sh1234_5678,
                1'b0, 1'b1, 11'd1);
    add_checked(CMD_INS_FRONT, 32'sh5A5A_5A5A, 1'b0, 32'sh1234_5678, 32'sh1234_5678,
                1'b0, 1'b1, 11'd1);
    add_checked(CMD_DEL_REAR,  32'sd0, 1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0);
    // capacity 0: empty and full at once, everything refused
    add_cap(11'd0);
    add_checked(CMD_DEL_FRONT, 32'sd0, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1, 11'd0);
    add_checked(CMD_INS_REAR,  32'sh0F0F_0F0F, 1'b0, EMPTY_WORD, EMPTY_WORD,
                1'b1, 1'b1, 11'd0);
    // all-ones capacity saturates at the ring depth
    add_cap(11'd2047);
    add_op(CMD_INS_REAR,  32'shA5A5_A5A5);
    add_op(CMD_INS_FRONT, 32'sd1);
    add_op(CMD_INS_REAR,  32'shFFFF_FFFE);
    // capacity lowered below the count: entries kept, inserts refused
    add_cap(11'd2);
    add_checked(CMD_INS_FRONT, 32'sd7, 1'b0, 32'sd1, 32'shFFFF_FFFE, 1'b0, 1'b1, 11'd3);
    add_op(CMD_DEL_FRONT, 32'sd0);
    add_op(CMD_DEL_REAR,  32'sd0);
    add_checked(CMD_DEL_FRONT, 32'sd0, 1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0);
    add_checked(CMD_DEL_REAR,  32'sd0, 1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles 28%, receiver 47%
    send_idle_pct = 28;
    recv_idle_pct = 47;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_capacity(directed_rows[i].cap);
      else
        send_op(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // small capacity: full and empty every few beats
    write_capacity(11'd3);
    run_random(150, MIX_UNIFORM);

    // roles swapped; fill the whole ring with the receiver held off at first,
    // so the block backs up and stalls its input
    send_idle_pct = 47;
    recv_idle_pct = 28;
    write_capacity(11'd2047);
    pressure_on = 1'b1;
    run_random(1030, MIX_INSERTS);

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(11'd1);      // far below a full ring
    run_random(60, MIX_UNIFORM);
    write_capacity(11'd0);      // held entries: inserts refused, deletes still served
    run_random(20, MIX_UNIFORM);
    write_capacity(CAP_RESET);
    run_random(60, MIX_UNIFORM);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
